// File: hdl/sbe_pkg.sv
// Shared constants, types and control structures of the stack bytecode executor.
package sbe_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VARIABLES   = 32;
    localparam int PC_BITS     = 16;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int VAR_BASE    = 97;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int VIDX_W      = $clog2(VARIABLES);
    localparam int DUMP_COUNT  = (VARIABLES < 32) ? VARIABLES : 32;

    typedef enum logic [3:0] {
        OP_FETCH = 4'd0,
        OP_STORE = 4'd1,
        OP_PUSH  = 4'd2,
        OP_POP   = 4'd3,
        OP_ADD   = 4'd4,
        OP_SUB   = 4'd5,
        OP_LESS  = 4'd6,
        OP_JZ    = 4'd7,
        OP_JNZ   = 4'd8,
        OP_JMP   = 4'd9,
        OP_HALT  = 4'd10
    } t_opcode;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_LESS
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_RESP,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [VIDX_W-1:0] rd_idx;
        logic              wr_en;
        logic [VIDX_W-1:0] wr_idx;
        logic [BYTE_W-1:0] wr_data;
        logic              clear;
    } t_var_ctrl;

endpackage

// File: hdl/stack_bytecode_executor_unit.sv
// Top level of the stack bytecode executor: sequencer, operand stack and result register.
//
//  Channel   Direction  Signals                      Contents
//  s_axis    in         tvalid/tready/tdata/tuser    one instruction per transaction
//  m_axis    out        tvalid/tready/tdata/tuser    step report or one dump entry
//                       tlast                        final result of an instruction
//
// An ordinary instruction occupies the block from the accepting edge until tready rises
// again (read, execute, result), and the result is held until m_axis tready takes it.
// The separate read state comes from the single registered read port of the operand
// stack: the top entry and the second entry are read one after the other.
// A halt passes through read and execute, then a dump read and a dump output per dumped
// variable (32 entries), each entry read from the variable store and held until taken.
// Reset is synchronous, active low; it empties the stack and zeroes every variable
// through valid bits, so no clearing pass is needed and tready is high right after.
module stack_bytecode_executor_unit import sbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Instruction input.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [31:0] argument, [47:32] current_pc
    input  logic [3:0]  i_s_axis_tuser,   // [3:0] opcode
    // Result output.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] next_pc, [20:16] variable_index,
                                          // [28:21] variable_value, [31:29] zero
    output logic [2:0]  o_m_axis_tuser,   // [0] result_kind, [1] halted, [2] error
    output logic        o_m_axis_tlast    // last
);

    // Sequencer state and the latched instruction.
    t_state               r_state;
    t_state               n_state;
    t_opcode              r_op;
    logic [WORD_W-1:0]    r_arg;
    logic [PC_BITS-1:0]   r_pc;

    // Architectural state kept in registers.
    logic [DEPTH_W-1:0]   r_depth;
    logic [DEPTH_W-1:0]   n_depth;
    logic                 r_err;
    logic                 n_err;
    logic [VIDX_W-1:0]    r_dump_idx;
    logic [WORD_W-1:0]    r_b;

    // Operand stack memory with one write port and one registered read port.
    logic [WORD_W-1:0]    r_stack [STACK_DEPTH];
    logic [WORD_W-1:0]    r_stack_rdata;
    logic                 stk_rd_en;
    logic [SP_W-1:0]      stk_rd_addr;
    logic                 stk_wr_en;
    logic [SP_W-1:0]      stk_wr_addr;
    logic [WORD_W-1:0]    stk_wr_data;

    // Result register.
    logic                 r_out_kind;
    logic [PC_BITS-1:0]   r_out_npc;
    logic                 r_out_halted;
    logic [VIDX_W-1:0]    r_out_vidx;
    logic [BYTE_W-1:0]    r_out_vval;
    logic                 r_out_err;
    logic                 r_out_last;

    // Datapath control and intermediate values.
    t_var_ctrl            var_ctrl;
    logic [BYTE_W-1:0]    var_rd;
    t_alu_op              alu_op;
    logic [WORD_W-1:0]    alu_y;
    logic                 in_accept;
    logic                 out_accept;
    logic [WORD_W-1:0]    in_vidx;
    logic [WORD_W-1:0]    vidx;
    logic                 vidx_ok;
    logic                 stk_empty;
    logic                 stk_full;
    logic                 stk_two;
    logic [WORD_W-1:0]    popped;
    logic [PC_BITS-1:0]   pc_inc1;
    logic [PC_BITS-1:0]   pc_inc2;
    logic [PC_BITS-1:0]   step_npc;
    logic                 load_step;
    logic                 load_dump;
    logic                 dump_last;
    logic                 dump_next;
    logic                 dump_start;

    assign in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_accept = o_m_axis_tvalid && i_m_axis_tready;

    // Variable codes are offset by the character code of 'a'.
    assign in_vidx = i_s_axis_tdata[WORD_W-1:0] - WORD_W'(VAR_BASE);
    assign vidx    = r_arg - WORD_W'(VAR_BASE);
    assign vidx_ok = (vidx < WORD_W'(VARIABLES));

    assign stk_empty = (r_depth == '0);
    assign stk_full  = (r_depth == DEPTH_W'(STACK_DEPTH));
    assign stk_two   = (r_depth >= DEPTH_W'(2));
    // An underflowing pop reads zero.
    assign popped    = stk_empty ? '0 : r_b;
    assign pc_inc1   = r_pc + PC_BITS'(1);
    assign pc_inc2   = r_pc + PC_BITS'(2);
    assign dump_last = (r_dump_idx == VIDX_W'(DUMP_COUNT - 1));

    always_comb begin
        unique case (r_op)
            OP_ADD:  alu_op = ALU_ADD;
            OP_SUB:  alu_op = ALU_SUB;
            default: alu_op = ALU_LESS;
        endcase
    end

    sbe_alu u_alu (
        .i_op (alu_op),
        .i_a  (r_stack_rdata),
        .i_b  (r_b),
        .o_y  (alu_y)
    );

    sbe_var_store u_var_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (var_ctrl),
        .o_rd_data (var_rd)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_accept) n_state = ST_READ;
            ST_READ:     n_state = ST_EXEC;
            ST_EXEC:     n_state = (r_op == OP_HALT) ? ST_DUMP_RD : ST_RESP;
            ST_RESP:     if (out_accept) n_state = ST_IDLE;
            ST_DUMP_RD:  n_state = ST_DUMP_OUT;
            ST_DUMP_OUT: if (out_accept) n_state = dump_last ? ST_IDLE : ST_DUMP_RD;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath control for each sequencer state. The top entry is read on the
    // accepting edge, the second entry in the read state, and the execute state
    // writes at most one stack entry and one variable.
    always_comb begin
        stk_rd_en   = 1'b0;
        stk_rd_addr = '0;
        stk_wr_en   = 1'b0;
        stk_wr_addr = '0;
        stk_wr_data = '0;
        var_ctrl    = '0;
        n_depth     = r_depth;
        n_err       = r_err;
        step_npc    = pc_inc1;
        load_step   = 1'b0;
        load_dump   = 1'b0;
        dump_next   = 1'b0;
        dump_start  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                stk_rd_en       = in_accept;
                stk_rd_addr     = SP_W'(r_depth - DEPTH_W'(1));
                var_ctrl.rd_en  = in_accept;
                var_ctrl.rd_idx = in_vidx[VIDX_W-1:0];
            end
            ST_READ: begin
                stk_rd_en   = 1'b1;
                stk_rd_addr = SP_W'(r_depth - DEPTH_W'(2));
            end
            ST_EXEC: begin
                load_step = (r_op != OP_HALT);
                unique case (r_op)
                    OP_FETCH: begin
                        step_npc = pc_inc2;
                        if (!vidx_ok || stk_full) begin
                            n_err = 1'b1;
                        end else begin
                            stk_wr_en   = 1'b1;
                            stk_wr_addr = r_depth[SP_W-1:0];
                            stk_wr_data = {{(WORD_W-BYTE_W){var_rd[BYTE_W-1]}}, var_rd};
                            n_depth     = r_depth + DEPTH_W'(1);
                        end
                    end
                    OP_STORE: begin
                        step_npc = pc_inc2;
                        if (stk_empty) begin
                            n_err = 1'b1;
                        end else begin
                            n_depth = r_depth - DEPTH_W'(1);
                        end
                        // An out-of-range store still pops and discards the value.
                        if (!vidx_ok) begin
                            n_err = 1'b1;
                        end else begin
                            var_ctrl.wr_en   = 1'b1;
                            var_ctrl.wr_idx  = vidx[VIDX_W-1:0];
                            var_ctrl.wr_data = popped[BYTE_W-1:0];
                        end
                    end
                    OP_PUSH: begin
                        step_npc = pc_inc2;
                        if (stk_full) begin
                            n_err = 1'b1;
                        end else begin
                            stk_wr_en   = 1'b1;
                            stk_wr_addr = r_depth[SP_W-1:0];
                            stk_wr_data = r_arg;
                            n_depth     = r_depth + DEPTH_W'(1);
                        end
                    end
                    OP_POP: begin
                        if (stk_empty) begin
                            n_err = 1'b1;
                        end else begin
                            n_depth = r_depth - DEPTH_W'(1);
                        end
                    end
                    OP_ADD, OP_SUB, OP_LESS: begin
                        if (!stk_two) begin
                            n_err = 1'b1;
                        end else begin
                            stk_wr_en   = 1'b1;
                            stk_wr_addr = SP_W'(r_depth - DEPTH_W'(2));
                            stk_wr_data = alu_y;
                            n_depth     = r_depth - DEPTH_W'(1);
                        end
                    end
                    OP_JZ, OP_JNZ: begin
                        if (stk_empty) begin
                            n_err = 1'b1;
                        end else begin
                            n_depth = r_depth - DEPTH_W'(1);
                        end
                        if ((r_op == OP_JZ) == (popped == '0)) begin
                            step_npc = r_arg[PC_BITS-1:0];
                        end else begin
                            step_npc = pc_inc2;
                        end
                    end
                    OP_JMP: begin
                        step_npc = r_arg[PC_BITS-1:0];
                    end
                    OP_HALT: begin
                        dump_start      = 1'b1;
                        var_ctrl.rd_en  = 1'b1;
                        var_ctrl.rd_idx = '0;
                    end
                    default: begin
                        step_npc = pc_inc1;
                    end
                endcase
            end
            ST_RESP: begin
            end
            ST_DUMP_RD: begin
                load_dump = 1'b1;
            end
            ST_DUMP_OUT: begin
                if (out_accept) begin
                    if (dump_last) begin
                        // The dump is complete: empty the stack and zero every variable.
                        var_ctrl.clear = 1'b1;
                        n_depth        = '0;
                    end else begin
                        dump_next       = 1'b1;
                        var_ctrl.rd_en  = 1'b1;
                        var_ctrl.rd_idx = r_dump_idx + VIDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_depth    <= '0;
            r_err      <= 1'b0;
            r_dump_idx <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_err   <= n_err;
            if (dump_start) begin
                r_dump_idx <= '0;
            end else if (dump_next) begin
                r_dump_idx <= r_dump_idx + VIDX_W'(1);
            end
        end
    end

    // Instruction latch and the top-of-stack copy taken in the read state.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= t_opcode'(i_s_axis_tuser);
            r_arg <= i_s_axis_tdata[WORD_W-1:0];
            r_pc  <= i_s_axis_tdata[WORD_W+PC_BITS-1:WORD_W];
        end
        if (r_state == ST_READ) begin
            r_b <= r_stack_rdata;
        end
    end

    // Operand stack memory.
    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            r_stack[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en) begin
            r_stack_rdata <= r_stack[stk_rd_addr];
        end
    end

    // Result register: a step report after execute, one dump entry per read.
    always_ff @(posedge i_clk) begin
        if (load_step) begin
            r_out_kind   <= 1'b0;
            r_out_npc    <= step_npc;
            r_out_halted <= 1'b0;
            r_out_vidx   <= '0;
            r_out_vval   <= '0;
            r_out_err    <= n_err;
            r_out_last   <= 1'b1;
        end else if (load_dump) begin
            r_out_kind   <= 1'b1;
            r_out_npc    <= r_pc;
            r_out_halted <= 1'b1;
            r_out_vidx   <= r_dump_idx;
            r_out_vval   <= var_rd;
            r_out_err    <= r_err;
            r_out_last   <= dump_last;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_RESP) || (r_state == ST_DUMP_OUT);
    assign o_m_axis_tdata  = {3'b000, r_out_vval, r_out_vidx, r_out_npc};
    assign o_m_axis_tuser  = {r_out_err, r_out_halted, r_out_kind};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("operand stack depth beyond its capacity");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("new instruction accepted while a result is pending");

    a_step_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tlast && !o_m_axis_tuser[1]))
        else $error("step report not marked as the only result");

    a_halt_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && o_m_axis_tuser[0] && o_m_axis_tlast) |=>
        (r_depth == '0 && o_s_axis_tready))
        else $error("stack not emptied after the variable dump");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("error flag dropped without reset");
`endif

endmodule

// File: hdl/sbe_alu.sv
// Shared arithmetic and compare unit for the binary stack instructions.
module sbe_alu import sbe_pkg::*; (
    input  t_alu_op           i_op,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic [WORD_W-1:0] o_y
);

    always_comb begin
        unique case (i_op)
            ALU_ADD:  o_y = i_a + i_b;
            ALU_SUB:  o_y = i_a - i_b;
            ALU_LESS: o_y = {{(WORD_W-1){1'b0}}, ($signed(i_a) < $signed(i_b))};
            default:  o_y = '0;
        endcase
    end

endmodule

// File: hdl/sbe_var_store.sv
// Byte-wide variable store with per-entry valid bits and a registered read port.
module sbe_var_store import sbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_var_ctrl         i_ctrl,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0]    r_mem [VARIABLES];
    logic [VARIABLES-1:0] r_valid;
    logic [BYTE_W-1:0]    r_rd_data;

    // An entry that was never written since reset or the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctrl.clear) begin
            r_valid <= '0;
        end else if (i_ctrl.wr_en) begin
            r_valid[i_ctrl.wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_idx] <= i_ctrl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_valid[i_ctrl.rd_idx] ? r_mem[i_ctrl.rd_idx] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
